@@ rtl/core/qosc_pkg.sv @@
// Shared types, constants and helpers for the quadrature oscillator.
package qosc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 18;
    localparam int AMP_W         = 23;
    localparam int SAMPLE_W      = 32;
    localparam int STEP_W        = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd12;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } ctrl_state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_KK,
        MUL_KX1,
        MUL_CX2,
        MUL_KX2,
        MUL_NXNX,
        MUL_NYNY,
        MUL_PS2,
        MUL_GNX,
        MUL_GNY,
        MUL_AMP
    } mul_op_t;

    typedef enum logic [3:0] {
        WR_NONE,
        WR_KK,
        WR_ACC,
        WR_NX,
        WR_NY,
        WR_S1,
        WR_S2,
        WR_G,
        WR_X1,
        WR_X2,
        WR_SAMPLE
    } wr_op_t;

    typedef struct packed {
        logic    load_start;
        logic    load_coef;
        mul_op_t mul_op;
        wr_op_t  wr_op;
    } dp_cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sh0_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -65'sh0_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/qosc_if.sv @@
// Channel interfaces: input word, output word and configuration write.
interface qosc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [qosc_pkg::COEF_W-1:0] cos_coef;

    modport source (output valid, kind, cos_coef, input ready);
    modport sink   (input valid, kind, cos_coef, output ready);
endinterface

interface qosc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [qosc_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

interface qosc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [qosc_pkg::AMP_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/quadrature_oscillator_agc_top.sv @@
// Top level of the amplitude-corrected quadrature sine oscillator.
//
//  channel | dir | payload            | handshake
//  --------+-----+--------------------+----------------
//  din     | in  | kind, cos_coef     | valid / ready
//  dout    | out | sample             | valid / ready
//  cfg     | in  | data (amplitude)   | valid / ready=1
//
// A start word loads the oscillator state when it is taken. A tick word is
// accepted and then runs 13 steps on the single shared 32x32 multiplier,
// which runs ten dependent products per sample.
// Reset clears the state to zero and amplitude to 1.0.
// A finished sample waits in the output register; a following start word
// is still taken, a following tick holds in its last step until dout frees.
module quadrature_oscillator_agc_top #(
    parameter int FRAC_BITS = qosc_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    qosc_in_if.sink     din,
    qosc_out_if.source  dout,
    qosc_cfg_if.sink    cfg
);

    qosc_pkg::dp_cmd_t cmd;

    assign cfg.ready = 1'b1;

    qosc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_kind   (din.kind),
        .in_ready  (din.ready),
        .out_ready (dout.ready),
        .out_valid (dout.valid),
        .cmd       (cmd)
    );

    qosc_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cos_coef (din.cos_coef),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.data),
        .sample   (dout.sample)
    );

endmodule

@@ rtl/core/qosc_ctrl.sv @@
// Sequencer: accepts words, steps the shared multiplier schedule, owns output valid.
module qosc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_kind,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    output qosc_pkg::dp_cmd_t cmd
);

    qosc_pkg::ctrl_state_t        state_reg, state_next;
    logic [qosc_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qosc_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == qosc_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.load_start = 1'b0;
        cmd.load_coef  = 1'b0;
        cmd.mul_op     = qosc_pkg::MUL_NONE;
        cmd.wr_op      = qosc_pkg::WR_NONE;
        unique case (state_reg)
            qosc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind)
                    begin
                        cmd.load_coef = 1'b1;
                        state_next    = qosc_pkg::ST_CALC;
                        step_next     = '0;
                    end
                    else
                    begin
                        cmd.load_start = 1'b1;
                    end
                end
            end
            qosc_pkg::ST_CALC:
            begin
                step_next = step_reg + 1'b1;
                unique case (step_reg)
                    4'd0:  cmd.mul_op = qosc_pkg::MUL_KK;
                    4'd1:
                    begin
                        cmd.mul_op = qosc_pkg::MUL_KX1;
                        cmd.wr_op  = qosc_pkg::WR_KK;
                    end
                    4'd2:
                    begin
                        cmd.mul_op = qosc_pkg::MUL_CX2;
                        cmd.wr_op  = qosc_pkg::WR_ACC;
                    end
                    4'd3:
                    begin
                        cmd.mul_op = qosc_pkg::MUL_KX2;
                        cmd.wr_op  = qosc_pkg::WR_NX;
                    end
                    4'd4:
                    begin
                        cmd.mul_op = qosc_pkg::MUL_NXNX;
                        cmd.wr_op  = qosc_pkg::WR_NY;
                    end
                    4'd5:
                    begin
                        cmd.mul_op = qosc_pkg::MUL_NYNY;
                        cmd.wr_op  = qosc_pkg::WR_S1;
                    end
                    4'd6:  cmd.wr_op = qosc_pkg::WR_S2;
                    4'd7:  cmd.mul_op = qosc_pkg::MUL_PS2;
                    4'd8:  cmd.wr_op = qosc_pkg::WR_G;
                    4'd9:  cmd.mul_op = qosc_pkg::MUL_GNX;
                    4'd10:
                    begin
                        cmd.mul_op = qosc_pkg::MUL_GNY;
                        cmd.wr_op  = qosc_pkg::WR_X1;
                    end
                    4'd11:
                    begin
                        cmd.mul_op = qosc_pkg::MUL_AMP;
                        cmd.wr_op  = qosc_pkg::WR_X2;
                    end
                    qosc_pkg::LAST_STEP:
                    begin
                        // hold here until the output register is free
                        step_next = step_reg;
                        if (out_free)
                        begin
                            cmd.wr_op      = qosc_pkg::WR_SAMPLE;
                            out_valid_next = 1'b1;
                            state_next     = qosc_pkg::ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = qosc_pkg::ST_IDLE;
                        step_next  = '0;
                    end
                endcase
            end
            default:
            begin
                state_next = qosc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/qosc_dp.sv @@
// Datapath: oscillator state, shared 32x32 multiplier, floor/saturate writeback.
module qosc_dp #(
    parameter int FRAC_BITS = qosc_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  qosc_pkg::dp_cmd_t                     cmd,
    input  logic signed [qosc_pkg::COEF_W-1:0]   cos_coef,
    input  logic                                  cfg_we,
    input  logic        [qosc_pkg::AMP_W-1:0]    cfg_data,
    output logic signed [qosc_pkg::SAMPLE_W-1:0] sample
);

    localparam int KK_W = 36 - FRAC_BITS;
    localparam logic signed [31:0] ONE        = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [64:0] THREE_HALF = 65'sd3 <<< (FRAC_BITS - 1);
    localparam logic [qosc_pkg::AMP_W-1:0] AMP_RESET =
        (FRAC_BITS >= qosc_pkg::AMP_W) ? '1 : (qosc_pkg::AMP_W'(1) << FRAC_BITS);

    logic signed [31:0]                  x1_reg, x2_reg;
    logic        [qosc_pkg::AMP_W-1:0]  amp_reg;
    logic signed [qosc_pkg::COEF_W-1:0] k_reg;
    logic signed [KK_W-1:0]              kk_reg;
    logic signed [63:0]                  acc_reg;
    logic signed [31:0]                  nx_reg, ny_reg, s1_reg, s2_reg, g_reg;
    logic signed [31:0]                  sample_reg;
    logic signed [63:0]                  prod_reg, prod_next;

    logic signed [31:0] mul_a, mul_b;
    logic signed [31:0] k_w, kk_w, amp_w;
    logic signed [63:0] prod_sh;
    logic signed [64:0] prod_ext, prod_sh_ext, nx_sum;
    logic signed [31:0] fl_val, nx_val, ny_val, p_val, g_val;

    assign k_w   = 32'(k_reg);
    assign kk_w  = 32'(kk_reg);
    assign amp_w = $signed({{(32 - qosc_pkg::AMP_W){1'b0}}, amp_reg});

    always_comb
    begin
        unique case (cmd.mul_op)
            qosc_pkg::MUL_NONE: begin mul_a = '0;          mul_b = '0;     end
            qosc_pkg::MUL_KK:   begin mul_a = k_w;         mul_b = k_w;    end
            qosc_pkg::MUL_KX1:  begin mul_a = k_w;         mul_b = x1_reg; end
            qosc_pkg::MUL_CX2:  begin mul_a = ONE - kk_w;  mul_b = x2_reg; end
            qosc_pkg::MUL_KX2:  begin mul_a = k_w;         mul_b = x2_reg; end
            qosc_pkg::MUL_NXNX: begin mul_a = nx_reg;      mul_b = nx_reg; end
            qosc_pkg::MUL_NYNY: begin mul_a = ny_reg;      mul_b = ny_reg; end
            qosc_pkg::MUL_PS2:  begin mul_a = kk_w - ONE;  mul_b = s2_reg; end
            qosc_pkg::MUL_GNX:  begin mul_a = g_reg;       mul_b = nx_reg; end
            qosc_pkg::MUL_GNY:  begin mul_a = g_reg;       mul_b = ny_reg; end
            qosc_pkg::MUL_AMP:  begin mul_a = amp_w;       mul_b = x1_reg; end
            default:            begin mul_a = '0;          mul_b = '0;     end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        prod_ext    = {prod_reg[63], prod_reg};
        prod_sh     = prod_reg >>> FRAC_BITS;
        prod_sh_ext = {prod_sh[63], prod_sh};
        nx_sum      = {acc_reg[63], acc_reg} + prod_ext;
        fl_val      = qosc_pkg::sat32(prod_sh_ext);
        nx_val      = qosc_pkg::sat32(nx_sum >>> FRAC_BITS);
        ny_val      = qosc_pkg::sat32(prod_sh_ext - 65'(x1_reg));
        p_val       = qosc_pkg::sat32(65'(s1_reg) - prod_sh_ext);
        g_val       = qosc_pkg::sat32(THREE_HALF - 65'(p_val));
    end

    // state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg  <= '0;
            x2_reg  <= '0;
            amp_reg <= AMP_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                amp_reg <= cfg_data;
            end
            if (cmd.load_start)
            begin
                x1_reg <= ONE;
                x2_reg <= 32'(cos_coef);
            end
            else if (cmd.wr_op == qosc_pkg::WR_X1)
            begin
                x1_reg <= fl_val;
            end
            else if (cmd.wr_op == qosc_pkg::WR_X2)
            begin
                x2_reg <= fl_val;
            end
        end
    end

    // intermediates
    always_ff @(posedge clk)
    begin
        if (cmd.load_coef)
        begin
            k_reg <= cos_coef;
        end
        if (cmd.mul_op != qosc_pkg::MUL_NONE)
        begin
            prod_reg <= prod_next;
        end
        unique case (cmd.wr_op)
            qosc_pkg::WR_NONE:   ;
            qosc_pkg::WR_KK:     kk_reg     <= prod_sh[KK_W-1:0];
            qosc_pkg::WR_ACC:    acc_reg    <= prod_reg;
            qosc_pkg::WR_NX:     nx_reg     <= nx_val;
            qosc_pkg::WR_NY:     ny_reg     <= ny_val;
            qosc_pkg::WR_S1:     s1_reg     <= fl_val;
            qosc_pkg::WR_S2:     s2_reg     <= fl_val;
            qosc_pkg::WR_G:      g_reg      <= g_val;
            qosc_pkg::WR_X1:     ;
            qosc_pkg::WR_X2:     ;
            qosc_pkg::WR_SAMPLE: sample_reg <= fl_val;
            default:             ;
        endcase
    end

    assign sample = sample_reg;

endmodule

@@ rtl/core/qosc_checker.sv @@
// Port-level checks for the oscillator top, attached by bind.
module qosc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        din_valid,
    input logic        din_ready,
    input logic        din_kind,
    input logic        dout_valid,
    input logic        dout_ready,
    input logic [31:0] dout_sample
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> dout_valid && $stable(dout_sample))
        else $error("output word changed or dropped while stalled");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        din_valid && din_ready && din_kind |=> !din_ready)
        else $error("input taken while a tick is in progress");

    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        din_valid && din_ready && !din_kind && !dout_valid |=> !dout_valid)
        else $error("start word produced an output word");

    a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
        din_valid && din_ready && din_kind && !dout_valid |-> ##14 dout_valid)
        else $error("tick result missing after 14 cycles");

endmodule

bind quadrature_oscillator_agc_top qosc_checker u_qosc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .din_valid   (din.valid),
    .din_ready   (din.ready),
    .din_kind    (din.kind),
    .dout_valid  (dout.valid),
    .dout_ready  (dout.ready),
    .dout_sample (dout.sample)
);

@@ verif/quadrature_oscillator_agc_top_tb.sv @@
// Self-checking testbench for the quadrature oscillator with amplitude correction.
`timescale 1ns / 100ps

module quadrature_oscillator_agc_top_tb;

    localparam int     FB             = qosc_pkg::FRAC_BITS_DEF;
    localparam longint ONE            = longint'(1) << FB;
    localparam logic   KIND_START     = 1'b0;
    localparam logic   KIND_TICK      = 1'b1;
    localparam int     CFG_AMPLITUDE  = 0;
    localparam int     SETTLE_CYCLES  = 16;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     CHUNK_WORDS    = 340;
    localparam int     DIR_ROWS       = 25;

    typedef struct packed {
        logic                               kind;
        logic signed [qosc_pkg::COEF_W-1:0] coef;
        logic                               known;
        logic signed [31:0]                 sample;
    } dir_row_t;

    logic clk;
    logic rst_n;

    qosc_in_if  din_ch ();
    qosc_out_if dout_ch ();
    qosc_cfg_if cfg_ch ();

    quadrature_oscillator_agc_top uut (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (din_ch),
        .dout (dout_ch),
        .cfg  (cfg_ch)
    );

    // oscillator state as predicted
    logic signed [31:0]         osc_i;
    logic signed [31:0]         osc_q;
    logic [qosc_pkg::AMP_W-1:0] amp_reg;

    logic signed [31:0] sample_q [$];
    int                 errors;
    int                 src_idle_pct;
    int                 snk_idle_pct;
    int                 hold_requests;
    int                 hold_served;
    int                 hold_left;
    int                 stall_cycles;

    // ticks before any start are all zero
    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{KIND_TICK,  18'sh1FFFF,    1'b1, 32'sd0},
        '{KIND_TICK,  18'sh20000,    1'b1, 32'sd0},
        '{KIND_TICK,  18'sd0,        1'b1, 32'sd0},
        '{KIND_START, 18'sd65536,    1'b0, 32'sd0},
        '{KIND_TICK,  18'sd65536,    1'b0, 32'sd0},
        '{KIND_TICK,  18'sd65536,    1'b0, 32'sd0},
        '{KIND_START, 18'sd0,        1'b0, 32'sd0},
        '{KIND_TICK,  18'sd0,        1'b1, 32'sd0},
        '{KIND_TICK,  18'sd0,        1'b0, 32'sd0},
        '{KIND_TICK,  18'sd0,        1'b0, 32'sd0},
        '{KIND_START, -18'sd65536,   1'b0, 32'sd0},
        '{KIND_TICK,  -18'sd65536,   1'b0, 32'sd0},
        '{KIND_TICK,  -18'sd65536,   1'b0, 32'sd0},
        '{KIND_START, 18'sh1FFFF,    1'b0, 32'sd0},
        '{KIND_TICK,  18'sh1FFFF,    1'b0, 32'sd0},
        '{KIND_TICK,  18'sh1FFFF,    1'b0, 32'sd0},
        '{KIND_START, 18'sh20000,    1'b0, 32'sd0},
        '{KIND_TICK,  18'sh20000,    1'b0, 32'sd0},
        '{KIND_TICK,  18'sh20000,    1'b0, 32'sd0},
        '{KIND_TICK,  18'sh20000,    1'b0, 32'sd0},
        '{KIND_START, 18'sd64000,    1'b0, 32'sd0},
        '{KIND_TICK,  18'sd64000,    1'b0, 32'sd0},
        '{KIND_TICK,  18'sd63000,    1'b0, 32'sd0},
        '{KIND_TICK,  18'sd64000,    1'b0, 32'sd0},
        '{KIND_START, -18'sd1,       1'b0, 32'sd0}
    };

    always #5 clk = ~clk;

    function automatic longint floor_fx(input longint v);
        return v >>> FB;
    endfunction

    function automatic longint clamp32(input longint v);
        longint r;
        if (v > 64'sh7FFF_FFFF)
        begin
            r = 64'sh7FFF_FFFF;
        end
        else if (v < -64'sh8000_0000)
        begin
            r = -64'sh8000_0000;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic void osc_start(input logic signed [qosc_pkg::COEF_W-1:0] coef);
        osc_i = 32'(clamp32(ONE));
        osc_q = 32'(clamp32(longint'(coef)));
    endfunction

    function automatic logic signed [31:0] osc_tick(
        input logic signed [qosc_pkg::COEF_W-1:0] coef
    );
        longint k;
        longint x1;
        longint x2;
        longint kk;
        longint nx;
        longint ny;
        longint s1;
        longint s2;
        longint p;
        longint g;
        k  = longint'(coef);
        x1 = longint'(osc_i);
        x2 = longint'(osc_q);
        kk = floor_fx(k * k);
        nx = clamp32(floor_fx(k * x1 + (ONE - kk) * x2));
        ny = clamp32(-x1 + floor_fx(k * x2));
        s1 = clamp32(floor_fx(nx * nx));
        s2 = clamp32(floor_fx(ny * ny));
        p  = clamp32(s1 - floor_fx((kk - ONE) * s2));
        g  = clamp32(ONE + ONE / 2 - p);
        osc_i = 32'(clamp32(floor_fx(g * nx)));
        osc_q = 32'(clamp32(floor_fx(g * ny)));
        return 32'(clamp32(floor_fx(longint'(amp_reg) * longint'(osc_i))));
    endfunction

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_word(input logic kind,
                             input logic signed [qosc_pkg::COEF_W-1:0] coef,
                             input logic known, input logic signed [31:0] typed);
        logic signed [31:0] s;
        while ($urandom_range(99) < src_idle_pct)
        begin
            din_ch.valid <= 1'b0;
            @(posedge clk);
        end
        din_ch.valid    <= 1'b1;
        din_ch.kind     <= kind;
        din_ch.cos_coef <= coef;
        do
            @(posedge clk);
        while (!din_ch.ready);
        if (kind == KIND_START)
        begin
            osc_start(coef);
        end
        else
        begin
            s = osc_tick(coef);
            sample_q.push_back(known ? typed : s);
        end
    endtask

    task automatic drain();
        din_ch.valid <= 1'b0;
        while (sample_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input int index, input logic [qosc_pkg::AMP_W-1:0] value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (index == CFG_AMPLITUDE)
        begin
            amp_reg = value;
        end
    endtask

    // output side: random stall, long hold-off on request, checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dout_ch.valid && dout_ch.ready)
            begin
                if (sample_q.size() == 0)
                begin
                    report_mismatch("sample with nothing pending", dout_ch.sample, 32'sd0);
                end
                else if (dout_ch.sample !== sample_q[0])
                begin
                    report_mismatch("sample", dout_ch.sample, sample_q.pop_front());
                end
                else
                begin
                    void'(sample_q.pop_front());
                end
            end
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dout_ch.ready <= 1'b0;
            end
            else
            begin
                dout_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int                                 sent;
        int                                 burst;
        int                                 base;
        int                                 coef_i;
        logic signed [qosc_pkg::COEF_W-1:0] coef;
        logic [qosc_pkg::AMP_W-1:0]         chunk_amp [0:4];

        clk             = 1'b0;
        rst_n           = 1'b0;
        din_ch.valid    = 1'b0;
        din_ch.kind     = KIND_START;
        din_ch.cos_coef = '0;
        dout_ch.ready   = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        errors          = 0;
        hold_requests   = 0;
        hold_served     = 0;
        hold_left       = 0;
        stall_cycles    = 0;
        src_idle_pct    = 23;
        snk_idle_pct    = 54;
        osc_i           = '0;
        osc_q           = '0;
        amp_reg         = qosc_pkg::AMP_W'(ONE);

        chunk_amp[0] = 23'h7FFFFF;
        chunk_amp[1] = 23'h000000;
        chunk_amp[2] = qosc_pkg::AMP_W'($urandom_range(0, 23'h7FFFFF));
        chunk_amp[3] = 23'h000001;
        chunk_amp[4] = qosc_pkg::AMP_W'(ONE);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_word(dir_rows[i].kind, dir_rows[i].coef, dir_rows[i].known,
                      dir_rows[i].sample);
        end

        for (int c = 0; c < 5; c++)
        begin
            src_idle_pct = (c < 2) ? 23 : (c < 4) ? 54 : 0;
            snk_idle_pct = (c < 2) ? 54 : (c < 4) ? 23 : 0;
            write_cfg(CFG_AMPLITUDE, chunk_amp[c]);
            if (c == 1 || c == 4)
            begin
                hold_requests++;
            end
            sent = 0;
            while (sent < CHUNK_WORDS)
            begin
                if ($urandom_range(99) < 10)
                begin
                    coef = qosc_pkg::COEF_W'($urandom);
                    send_word(logic'($urandom_range(1)), coef, 1'b0, 32'sd0);
                    sent++;
                end
                else
                begin
                    case ($urandom_range(9))
                        0:       base = 65536;
                        1:       base = -65536;
                        default: base = int'($urandom_range(0, 131072)) - 65536;
                    endcase
                    coef = qosc_pkg::COEF_W'(base);
                    send_word(KIND_START, coef, 1'b0, 32'sd0);
                    burst = $urandom_range(4, 40);
                    for (int t = 0; t < burst; t++)
                    begin
                        coef_i = base;
                        if ($urandom_range(1) == 1)
                        begin
                            coef_i = base + int'($urandom_range(0, 200)) - 100;
                        end
                        coef = qosc_pkg::COEF_W'(coef_i);
                        send_word(KIND_TICK, coef, 1'b0, 32'sd0);
                    end
                    sent += burst + 1;
                end
            end
        end

        drain();
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/qosc_pkg.sv
rtl/core/qosc_if.sv
rtl/core/qosc_ctrl.sv
rtl/core/qosc_dp.sv
rtl/core/quadrature_oscillator_agc_top.sv
rtl/core/qosc_checker.sv
verif/quadrature_oscillator_agc_top_tb.sv
